// ----- hdl/gjmi_pkg.sv -----
// ----------------------------------------------------------------------------
// gjmi_pkg
// Shared constants, types and helpers for the Gauss-Jordan inverse unit.
// ----------------------------------------------------------------------------
package gjmi_pkg;

    localparam int MAX_SIZE  = 8;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int CNT_W     = IDX_W + 1;
    // word address inside a row cell: msb picks companion half
    localparam int ADDR_W    = IDX_W + 1;
    localparam int WORDS     = 2 * MAX_SIZE;
    // numerator width of the divider
    localparam int NUM_W     = DATA_W + FRAC_BITS;

    localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_all;
        logic              wr_init;
        logic [IDX_W-1:0]  wr_row;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [IDX_W-1:0]  piv_row;
        logic              f_load;
        logic              swap_en;
        logic [IDX_W-1:0]  swap_a;
        logic [IDX_W-1:0]  swap_b;
        // rows in use; rows at or above this take no elimination
        logic [CNT_W-1:0]  n_rows;
    } cell_ctrl_t;

    // pivot-row word travelling down the chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } token_t;

    // magnitude of a two's complement word (most negative fits unsigned)
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
        return r;
    endfunction

    // next word of a row sweep: work columns from the pivot, then companion
    // columns from zero; top bit flags the end of the sweep
    function automatic logic [ADDR_W:0] seq_next(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] c1;
        logic [ADDR_W:0]  r;
        c1 = CNT_W'(a[IDX_W-1:0]) + CNT_W'(1);
        if (c1 < n) begin
            r = {1'b0, a[IDX_W], c1[IDX_W-1:0]};
        end else if (!a[IDX_W]) begin
            r = {1'b0, 1'b1, {IDX_W{1'b0}}};
        end else begin
            r = {1'b1, 1'b1, {IDX_W{1'b0}}};
        end
        return r;
    endfunction

endpackage

// ----- hdl/gauss_jordan_matrix_inverse_unit.sv -----
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_unit
// Fixed-point matrix inverse by Gauss-Jordan elimination, partial pivoting.
// ----------------------------------------------------------------------------
// Load: one element per cycle. After the last item, the companion fill, then
// per column i: pivot search and swap, 2n-i divides, 2n-i words issued into
// the row-cell chain and a drain of the chain; a zero pivot skips the
// divides and the chain. The inverse streams out at one item per cycle while
// m_ready holds. One matrix in flight at a time. Reset clears control and
// sets matrix_size to 8; matrix storage is not cleared.
module gauss_jordan_matrix_inverse_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [3:0]                  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_element_value,
    input  logic [2:0]                  s_element_row,
    input  logic [2:0]                  s_element_col,
    input  logic                        s_load_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_inverse_value,
    output logic [2:0]                  m_inverse_row,
    output logic [2:0]                  m_inverse_col,
    output logic                        m_result_last,
    output logic                        m_singular
);
    localparam int IW = gjmi_pkg::IDX_W;
    localparam int CW = gjmi_pkg::CNT_W;
    localparam int AW = gjmi_pkg::ADDR_W;
    localparam int DRW = $clog2(gjmi_pkg::MAX_SIZE + 4);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_INIT      = 11'b00000000010,
        ST_SEARCH    = 11'b00000000100,
        ST_SWAP      = 11'b00000001000,
        ST_PIVOT     = 11'b00000010000,
        ST_NORM_GO   = 11'b00000100000,
        ST_NORM_WAIT = 11'b00001000000,
        ST_ELIM      = 11'b00010000000,
        ST_DRAIN     = 11'b00100000000,
        ST_EMIT      = 11'b01000000000,
        ST_LAST      = 11'b10000000000
    } state_t;

    state_t             state_reg;
    logic [3:0]         size_reg;
    logic [CW-1:0]      n_reg;
    logic [IW-1:0]      i_reg;
    logic [CW-1:0]      r_reg;
    logic [IW-1:0]      best_reg;
    logic [31:0]        bestmag_reg;
    logic [31:0]        pivot_reg;
    logic [AW-1:0]      addr_reg;
    logic [IW-1:0]      fill_reg;
    logic [DRW-1:0]     drain_reg;
    logic               sing_reg;
    logic [IW-1:0]      orow_reg;
    logic [IW-1:0]      ocol_reg;
    gjmi_pkg::token_t   tok_reg;
    gjmi_pkg::token_t   tok_next;

    logic               m_valid_reg;
    logic [31:0]        m_value_reg;
    logic [IW-1:0]      m_row_reg;
    logic [IW-1:0]      m_col_reg;
    logic               m_last_reg;
    logic               m_sing_reg;

    gjmi_pkg::cell_ctrl_t ctrl;
    gjmi_pkg::token_t   chain [gjmi_pkg::MAX_SIZE+1];
    logic [31:0]        cell_rd  [gjmi_pkg::MAX_SIZE];
    logic [IW-1:0]      cell_tag [gjmi_pkg::MAX_SIZE];
    logic [gjmi_pkg::MAX_SIZE-1:0] cell_sat;

    logic [IW-1:0]      sel_row;
    logic [31:0]        sel_data;
    logic [31:0]        sel_mag;
    logic [CW-1:0]      n_eff;
    logic [AW:0]        seq;
    logic               s_fire;
    logic               out_free;
    logic               col_more;
    logic               emit_last;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_q;
    logic               div_sat;

    assign s_ready  = state_reg == ST_IDLE;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sel_mag  = gjmi_pkg::mag32(sel_data);
    assign seq      = gjmi_pkg::seq_next(addr_reg, n_reg);
    assign col_more = (CW'(i_reg) + CW'(1)) < n_reg;
    assign emit_last = ((CW'(orow_reg) + CW'(1)) == n_reg)
                    && ((CW'(ocol_reg) + CW'(1)) == n_reg);

    // effective size: zero acts as one, above the maximum clamps
    assign n_eff = (size_reg == 4'd0) ? CW'(1) :
                   (size_reg > 4'(gjmi_pkg::MAX_SIZE)) ? CW'(gjmi_pkg::MAX_SIZE) :
                   CW'(size_reg);

    // pick the cell currently holding the selected row
    always_comb begin
        sel_data = '0;
        for (int k = 0; k < gjmi_pkg::MAX_SIZE; k++) begin
            if (cell_tag[k] == sel_row) begin
                sel_data = cell_rd[k];
            end
        end
    end

    // per-state control to the cells
    always_comb begin
        ctrl          = '0;
        ctrl.piv_row  = i_reg;
        ctrl.swap_a   = i_reg;
        ctrl.swap_b   = best_reg;
        ctrl.rd_addr  = {1'b0, i_reg};
        ctrl.n_rows   = n_reg;
        sel_row       = i_reg;
        tok_next      = '0;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.wr_en   = s_fire;
                ctrl.wr_row  = s_element_row;
                ctrl.wr_addr = {1'b0, s_element_col};
                ctrl.wr_data = s_element_value;
            end
            ST_INIT: begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_all  = 1'b1;
                ctrl.wr_init = 1'b1;
                ctrl.wr_addr = {1'b1, fill_reg};
            end
            ST_SEARCH: begin
                sel_row = r_reg[IW-1:0];
            end
            ST_SWAP: begin
                ctrl.swap_en = 1'b1;
            end
            ST_PIVOT: begin
                ctrl.f_load = 1'b1;
            end
            ST_NORM_GO: begin
                ctrl.rd_addr = addr_reg;
                div_start    = 1'b1;
            end
            ST_NORM_WAIT: begin
                ctrl.wr_en   = div_done;
                ctrl.wr_row  = i_reg;
                ctrl.wr_addr = addr_reg;
                ctrl.wr_data = div_q;
            end
            ST_ELIM: begin
                ctrl.rd_addr   = addr_reg;
                tok_next.valid = 1'b1;
                tok_next.idx   = addr_reg;
                tok_next.data  = sel_data;
            end
            ST_DRAIN: begin
            end
            ST_EMIT: begin
                ctrl.rd_addr = {1'b1, ocol_reg};
                sel_row      = orow_reg;
            end
            ST_LAST: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            size_reg      <= 4'd8;
            sing_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            tok_reg       <= '0;
        end else begin
            tok_reg       <= tok_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (|cell_sat) begin
                sing_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_load_last) begin
                        n_reg     <= n_eff;
                        fill_reg  <= '0;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    fill_reg <= fill_reg + IW'(1);
                    sing_reg <= 1'b0;
                    if (fill_reg == IW'(gjmi_pkg::MAX_SIZE - 1)) begin
                        i_reg     <= '0;
                        r_reg     <= '0;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if ((r_reg == CW'(i_reg)) || (sel_mag > bestmag_reg)) begin
                        best_reg    <= r_reg[IW-1:0];
                        bestmag_reg <= sel_mag;
                    end
                    r_reg <= r_reg + CW'(1);
                    if ((r_reg + CW'(1)) >= n_reg) begin
                        state_reg <= ST_SWAP;
                    end
                end
                ST_SWAP: begin
                    state_reg <= ST_PIVOT;
                end
                ST_PIVOT: begin
                    pivot_reg <= sel_data;
                    addr_reg  <= {1'b0, i_reg};
                    if (sel_data == '0) begin
                        sing_reg <= 1'b1;
                        if (col_more) begin
                            i_reg     <= i_reg + IW'(1);
                            r_reg     <= CW'(i_reg) + CW'(1);
                            state_reg <= ST_SEARCH;
                        end else begin
                            orow_reg  <= '0;
                            ocol_reg  <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end else begin
                        state_reg <= ST_NORM_GO;
                    end
                end
                ST_NORM_GO: begin
                    state_reg <= ST_NORM_WAIT;
                end
                ST_NORM_WAIT: begin
                    if (div_done) begin
                        if (div_sat) begin
                            sing_reg <= 1'b1;
                        end
                        if (seq[AW]) begin
                            addr_reg  <= {1'b0, i_reg};
                            state_reg <= ST_ELIM;
                        end else begin
                            addr_reg  <= seq[AW-1:0];
                            state_reg <= ST_NORM_GO;
                        end
                    end
                end
                ST_ELIM: begin
                    addr_reg <= seq[AW-1:0];
                    if (seq[AW]) begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + DRW'(1);
                    if (drain_reg == DRW'(gjmi_pkg::MAX_SIZE + 3)) begin
                        if (col_more) begin
                            i_reg     <= i_reg + IW'(1);
                            r_reg     <= CW'(i_reg) + CW'(1);
                            state_reg <= ST_SEARCH;
                        end else begin
                            orow_reg  <= '0;
                            ocol_reg  <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if ((CW'(ocol_reg) + CW'(1)) == n_reg) begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + IW'(1);
                        end else begin
                            ocol_reg <= ocol_reg + IW'(1);
                        end
                        if (emit_last) begin
                            state_reg <= ST_LAST;
                        end
                    end
                end
                ST_LAST: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output item
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            m_value_reg <= sel_data;
            m_row_reg   <= orow_reg;
            m_col_reg   <= ocol_reg;
            m_last_reg  <= emit_last;
            m_sing_reg  <= sing_reg;
        end
    end

    // shared divider for pivot-row normalisation
    gjmi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_in  (sel_data),
        .den_in  (pivot_reg),
        .done    (div_done),
        .quo     (div_q),
        .sat     (div_sat)
    );

    // row-cell chain
    assign chain[0] = tok_reg;
    for (genvar k = 0; k < gjmi_pkg::MAX_SIZE; k++) begin : g_cell
        gjmi_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_id (IW'(k)),
            .ctrl    (ctrl),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1]),
            .rd_data (cell_rd[k]),
            .tag     (cell_tag[k]),
            .sat     (cell_sat[k])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_inverse_value = m_value_reg;
    assign m_inverse_row   = m_row_reg;
    assign m_inverse_col   = m_col_reg;
    assign m_result_last   = m_last_reg;
    assign m_singular      = m_sing_reg;

endmodule

// ----- hdl/gjmi_div.sv -----
// ----------------------------------------------------------------------------
// gjmi_div
// Radix-2 restoring fixed-point divider, rounds to nearest, saturates.
// ----------------------------------------------------------------------------
module gjmi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gjmi_pkg::DATA_W-1:0] num_in,
    input  logic [gjmi_pkg::DATA_W-1:0] den_in,
    output logic                        done,
    output logic [gjmi_pkg::DATA_W-1:0] quo,
    output logic                        sat
);
    localparam int CW = $clog2(gjmi_pkg::NUM_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CW-1:0]                cnt_reg;
    logic [gjmi_pkg::NUM_W-1:0]   num_reg;
    logic [gjmi_pkg::NUM_W-1:0]   quo_reg;
    logic [gjmi_pkg::DATA_W:0]    rem_reg;
    logic [gjmi_pkg::DATA_W-1:0]  den_reg;
    logic                         neg_reg;

    logic [gjmi_pkg::DATA_W:0]    trial;
    logic                         fits;
    logic [gjmi_pkg::DATA_W-1:0]  den_mag;
    logic [gjmi_pkg::NUM_W-1:0]   num_start;
    logic                         sat_pos;
    logic                         sat_neg;
    logic [gjmi_pkg::NUM_W-1:0]   quo_neg;

    // numerator is |a| << FRAC_BITS plus half the divisor for rounding
    assign den_mag   = gjmi_pkg::mag32(den_in);
    assign num_start = {gjmi_pkg::mag32(num_in), {gjmi_pkg::FRAC_BITS{1'b0}}}
                     + gjmi_pkg::NUM_W'(den_mag >> 1);

    assign trial = {rem_reg[gjmi_pkg::DATA_W-1:0], num_reg[gjmi_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(gjmi_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num_start;
            den_reg <= den_mag;
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= num_in[gjmi_pkg::DATA_W-1] ^ den_in[gjmi_pkg::DATA_W-1];
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[gjmi_pkg::NUM_W-2:0], fits};
        end
    end

    // sign and saturation
    assign quo_neg = ~quo_reg + gjmi_pkg::NUM_W'(1);
    assign sat_pos = !neg_reg && (quo_reg > gjmi_pkg::NUM_W'(gjmi_pkg::SAT_MAX));
    assign sat_neg = neg_reg && (quo_reg > gjmi_pkg::NUM_W'(gjmi_pkg::SAT_MIN));
    assign sat     = sat_pos || sat_neg;
    assign done    = done_reg;
    assign quo     = sat_pos ? gjmi_pkg::SAT_MAX :
                     sat_neg ? gjmi_pkg::SAT_MIN :
                     neg_reg ? quo_neg[gjmi_pkg::DATA_W-1:0] :
                               quo_reg[gjmi_pkg::DATA_W-1:0];

endmodule

// ----- hdl/gjmi_cell.sv -----
// ----------------------------------------------------------------------------
// gjmi_cell
// One matrix row cell: work and companion words, row tag and a two-stage
// multiply-subtract fed by the pivot-row item passing down the chain.
// ----------------------------------------------------------------------------
module gjmi_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [gjmi_pkg::IDX_W-1:0]  cell_id,
    input  gjmi_pkg::cell_ctrl_t        ctrl,
    input  gjmi_pkg::token_t            tok_in,
    output gjmi_pkg::token_t            tok_out,
    output logic [gjmi_pkg::DATA_W-1:0] rd_data,
    output logic [gjmi_pkg::IDX_W-1:0]  tag,
    output logic                        sat
);
    localparam int DW = 2 * gjmi_pkg::DATA_W + 2;

    logic [gjmi_pkg::DATA_W-1:0]   mem_reg [gjmi_pkg::WORDS];
    logic [gjmi_pkg::IDX_W-1:0]    tag_reg;
    logic [gjmi_pkg::DATA_W-1:0]   f_reg;
    gjmi_pkg::token_t              tok_reg;

    logic                          s1_valid_reg;
    logic [gjmi_pkg::ADDR_W-1:0]   s1_idx_reg;
    logic [gjmi_pkg::DATA_W-1:0]   s1_old_reg;
    logic [2*gjmi_pkg::DATA_W-1:0] s1_prod_reg;
    logic                          s1_neg_reg;

    logic                          is_piv;
    logic                          in_use;
    logic                          use_tok;
    logic [gjmi_pkg::ADDR_W-1:0]   rd_addr;
    logic [2*gjmi_pkg::DATA_W-1:0] prod;
    logic [2*gjmi_pkg::DATA_W-1:0] rnd;
    logic signed [DW-1:0]          diff;
    logic                          sat_hi;
    logic                          sat_lo;
    logic [gjmi_pkg::DATA_W-1:0]   res;
    logic                          ext_hit;
    logic [gjmi_pkg::DATA_W-1:0]   ext_data;

    // the pivot row feeds the chain and takes no update itself; rows outside
    // the matrix in use are left alone
    assign is_piv  = tag_reg == ctrl.piv_row;
    assign in_use  = gjmi_pkg::CNT_W'(tag_reg) < ctrl.n_rows;
    assign use_tok = tok_in.valid && !is_piv && in_use;
    assign rd_addr = use_tok ? tok_in.idx : ctrl.rd_addr;
    assign rd_data = mem_reg[rd_addr];
    assign tag     = tag_reg;
    assign tok_out = tok_reg;

    // stage 1: magnitude product
    assign prod = {{gjmi_pkg::DATA_W{1'b0}}, gjmi_pkg::mag32(f_reg)}
                * {{gjmi_pkg::DATA_W{1'b0}}, gjmi_pkg::mag32(tok_in.data)};

    // stage 2: round, apply sign, subtract, saturate
    assign rnd  = (s1_prod_reg + (2*gjmi_pkg::DATA_W)'(64'd1 << (gjmi_pkg::FRAC_BITS - 1)))
                >> gjmi_pkg::FRAC_BITS;
    assign diff = $signed({{(DW-gjmi_pkg::DATA_W){s1_old_reg[gjmi_pkg::DATA_W-1]}}, s1_old_reg})
                - (s1_neg_reg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd}));
    assign sat_hi = diff > $signed(DW'(gjmi_pkg::SAT_MAX));
    assign sat_lo = diff < -$signed(DW'(gjmi_pkg::SAT_MIN));
    assign res    = sat_hi ? gjmi_pkg::SAT_MAX :
                    sat_lo ? gjmi_pkg::SAT_MIN : diff[gjmi_pkg::DATA_W-1:0];
    assign sat    = s1_valid_reg && (sat_hi || sat_lo);

    // external write: load, normalise, or identity fill
    assign ext_hit  = ctrl.wr_en && (ctrl.wr_all || (tag_reg == ctrl.wr_row));
    assign ext_data = !ctrl.wr_init ? ctrl.wr_data :
                      (ctrl.wr_addr[gjmi_pkg::IDX_W-1:0] == tag_reg) ? gjmi_pkg::FX_ONE :
                      '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg       <= cell_id;
            tok_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            tok_reg       <= tok_in;
            s1_valid_reg  <= use_tok;
            if (ctrl.swap_en) begin
                if (tag_reg == ctrl.swap_a) begin
                    tag_reg <= ctrl.swap_b;
                end else if (tag_reg == ctrl.swap_b) begin
                    tag_reg <= ctrl.swap_a;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_idx_reg   <= tok_in.idx;
        s1_old_reg   <= rd_data;
        s1_prod_reg  <= prod;
        s1_neg_reg   <= f_reg[gjmi_pkg::DATA_W-1] ^ tok_in.data[gjmi_pkg::DATA_W-1];
        if (ctrl.f_load) begin
            f_reg <= rd_data;
        end
        if (s1_valid_reg) begin
            mem_reg[s1_idx_reg] <= res;
        end else if (ext_hit) begin
            mem_reg[ctrl.wr_addr] <= ext_data;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Gauss-Jordan matrix inverse unit. Matrices are loaded
// one element per item under random valid and ready idling. Every inverse
// is checked, element by element, against a fixed-point elimination model
// kept in the testbench, or against typed values for some size-one loads.
// Matrix size is changed between matrices, once the unit has gone idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIZE   = gjmi_pkg::MAX_SIZE;
    localparam int FRAC_BITS  = gjmi_pkg::FRAC_BITS;
    localparam int NO_CFG     = -1;
    localparam int ITEM_COUNT = 230;
    localparam int QUIET_FROM = 200;
    localparam int SETTLE     = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_element_value = '0;
    logic [2:0]  s_element_row = '0;
    logic [2:0]  s_element_col = '0;
    logic        s_load_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_inverse_value;
    logic [2:0]  m_inverse_row;
    logic [2:0]  m_inverse_col;
    logic        m_result_last;
    logic        m_singular;

    gauss_jordan_matrix_inverse_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .s_element_row   (s_element_row),
        .s_element_col   (s_element_col),
        .s_load_last     (s_load_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inverse_value (m_inverse_value),
        .m_inverse_row   (m_inverse_row),
        .m_inverse_col   (m_inverse_col),
        .m_result_last   (m_result_last),
        .m_singular      (m_singular)
    );

    always #1 aclk = ~aclk;

    // inverse element as it should leave the unit
    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        sing;
    } inv_elem_t;

    // directed load: optional size write before it, optional typed result
    typedef struct {
        int          cfg;
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        bit          typed;
        logic [31:0] exp_value;
        logic        exp_sing;
    } load_row_t;

    inv_elem_t pending_inverse[$];

    // model state
    int       work_cells [MAX_SIZE*MAX_SIZE];
    int       comp_cells [MAX_SIZE*MAX_SIZE];
    bit       cell_written [MAX_SIZE*MAX_SIZE];
    bit       sing_flag;
    logic [3:0] size_reg = 4'd8;

    int  items_sent = 0;
    int  mismatches = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    function automatic longint magn(input int v);
        return v < 0 ? -longint'(v) : longint'(v);
    endfunction

    // saturate to 32 bits, noting overflow
    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            sing_flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sing_flag = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // a / p, round half away from zero
    function automatic int fx_quot(input int a, input int p);
        bit neg;
        longint unsigned den, q;
        neg = (a < 0) != (p < 0);
        den = longint'(magn(p));
        q = ((longint'(magn(a)) << FRAC_BITS) + den / 2) / den;
        return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    // f * y, round half away from zero, unsaturated
    function automatic longint fx_prod(input int f, input int y);
        bit neg;
        longint unsigned m, r;
        neg = (f < 0) != (y < 0);
        m = longint'(magn(f)) * longint'(magn(y));
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic int eff_size(input logic [3:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIZE) return MAX_SIZE;
        return int'(s);
    endfunction

    // elimination on the model matrices, then queue the expected inverse
    function automatic void run_inverse();
        int n, best, pivot, f, t;
        inv_elem_t e;
        n = eff_size(size_reg);
        for (int k = 0; k < MAX_SIZE*MAX_SIZE; k++) comp_cells[k] = 0;
        for (int k = 0; k < MAX_SIZE; k++) comp_cells[k*MAX_SIZE+k] = 1 << FRAC_BITS;
        sing_flag = 1'b0;
        for (int i = 0; i < n; i++) begin
            best = i;
            for (int j = i + 1; j < n; j++)
                if (magn(work_cells[j*MAX_SIZE+i]) > magn(work_cells[best*MAX_SIZE+i]))
                    best = j;
            if (best != i) begin
                for (int j = 0; j < MAX_SIZE; j++) begin
                    t = work_cells[i*MAX_SIZE+j];
                    work_cells[i*MAX_SIZE+j] = work_cells[best*MAX_SIZE+j];
                    work_cells[best*MAX_SIZE+j] = t;
                    t = comp_cells[i*MAX_SIZE+j];
                    comp_cells[i*MAX_SIZE+j] = comp_cells[best*MAX_SIZE+j];
                    comp_cells[best*MAX_SIZE+j] = t;
                end
            end
            pivot = work_cells[i*MAX_SIZE+i];
            if (pivot == 0) begin
                sing_flag = 1'b1;
                continue;
            end
            for (int j = i; j < n; j++)
                work_cells[i*MAX_SIZE+j] = fx_quot(work_cells[i*MAX_SIZE+j], pivot);
            for (int j = 0; j < n; j++)
                comp_cells[i*MAX_SIZE+j] = fx_quot(comp_cells[i*MAX_SIZE+j], pivot);
            for (int k = 0; k < n; k++) begin
                if (k == i) continue;
                f = work_cells[k*MAX_SIZE+i];
                for (int j = i; j < n; j++)
                    work_cells[k*MAX_SIZE+j] = clamp32(longint'(work_cells[k*MAX_SIZE+j])
                        - fx_prod(f, work_cells[i*MAX_SIZE+j]));
                for (int j = 0; j < n; j++)
                    comp_cells[k*MAX_SIZE+j] = clamp32(longint'(comp_cells[k*MAX_SIZE+j])
                        - fx_prod(f, comp_cells[i*MAX_SIZE+j]));
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                e.value = comp_cells[r*MAX_SIZE+c];
                e.row   = 3'(r);
                e.col   = 3'(c);
                e.last  = (r == n - 1) && (c == n - 1);
                e.sing  = sing_flag;
                pending_inverse.push_back(e);
            end
        end
    endfunction

    // one item through the input channel, then maybe a gap
    task automatic send_elem(input logic [31:0] v, input logic [2:0] r,
                             input logic [2:0] c, input logic last);
        s_valid         <= 1'b1;
        s_element_value <= v;
        s_element_row   <= r;
        s_element_col   <= c;
        s_load_last     <= last;
        do @(posedge aclk); while (!s_ready);
        work_cells[{r, c}] = int'(v);
        cell_written[{r, c}] = 1'b1;
        if (last) run_inverse();
        items_sent++;
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // wait for the unit to go idle, then write the size register
    task automatic write_size(input logic [3:0] v);
        s_valid <= 1'b0;
        while (pending_inverse.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_reg = v;
    endtask

    function automatic logic [31:0] rand_elem();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 32'($urandom_range(0, 524288)) - 32'd262144;
        if (pick < 80) return 32'd0;
        if (pick < 83) return 32'h80000000;
        if (pick < 86) return 32'h7FFFFFFF;
        return $urandom;
    endfunction

    // result receiver: bursts of stall
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        inv_elem_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_inverse.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: value %h row %0d col %0d",
                             m_inverse_value, m_inverse_row, m_inverse_col);
            end else begin
                e = pending_inverse.pop_front();
                if (m_inverse_value !== e.value || m_inverse_row !== e.row ||
                    m_inverse_col !== e.col || m_result_last !== e.last ||
                    m_singular !== e.sing) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h r%0d c%0d l%b s%b, got %h r%0d c%0d l%b s%b",
                                 e.value, e.row, e.col, e.last, e.sing,
                                 m_inverse_value, m_inverse_row, m_inverse_col,
                                 m_result_last, m_singular);
                end
            end
        end
    end

    // directed loads: single elements first (zero pivot, unit, saturation,
    // most negative), size 0 acting as 1, a swap, then a pivot tie
    load_row_t plan [20] = '{
        '{1,      32'h00000000, 0, 0, 1, 1, 32'h00010000, 1},
        '{NO_CFG, 32'h00010000, 0, 0, 1, 1, 32'h00010000, 0},
        '{NO_CFG, 32'h00000001, 0, 0, 1, 1, 32'h7FFFFFFF, 1},
        '{NO_CFG, 32'hFFFFFFFF, 0, 0, 1, 1, 32'h80000000, 1},
        '{NO_CFG, 32'h80000000, 0, 0, 1, 1, 32'hFFFFFFFE, 0},
        '{NO_CFG, 32'h7FFFFFFF, 0, 0, 1, 0, 32'h0, 0},
        '{0,      32'hFFFF0000, 0, 0, 1, 1, 32'hFFFF0000, 0},
        '{2,      32'h00000000, 0, 0, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00010000, 0, 1, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00020000, 1, 0, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00000000, 1, 1, 1, 0, 32'h0, 0},
        '{3,      32'h00010000, 0, 0, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00020000, 0, 1, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00000000, 0, 2, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'hFFFF0000, 1, 0, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00000000, 1, 1, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00010000, 1, 2, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00010000, 2, 0, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00010000, 2, 1, 0, 0, 32'h0, 0},
        '{NO_CFG, 32'h00030000, 2, 2, 1, 0, 32'h0, 0}
    };

    // stimulus
    initial begin
        int n, phase, sel, k;
        logic [3:0] cfgv;
        bit need_full;
        for (int i = 0; i < MAX_SIZE*MAX_SIZE; i++) cell_written[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].cfg != NO_CFG) write_size(4'(plan[i].cfg));
            send_elem(plan[i].value, plan[i].row, plan[i].col, plan[i].last);
            // size-one results are typed in directly
            if (plan[i].typed) begin
                pending_inverse[$].value = plan[i].exp_value;
                pending_inverse[$].sing  = plan[i].exp_sing;
            end
        end

        // random matrices; first full size, then size above the maximum, then random sizes
        phase = 0;
        while (items_sent < ITEM_COUNT) begin
            if (phase == 0) cfgv = 4'd8;
            else if (phase == 1) cfgv = 4'd15;
            else begin
                sel = $urandom_range(0, 9);
                if (sel < 5) cfgv = 4'($urandom_range(1, 4));
                else if (sel < 7) cfgv = 4'($urandom_range(5, 8));
                else cfgv = 4'($urandom_range(0, 15));
            end
            phase++;
            write_size(cfgv);
            n = eff_size(cfgv);
            repeat ($urandom_range(1, 3)) begin
                if (items_sent >= ITEM_COUNT) break;
                need_full = 1'b0;
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        if (!cell_written[r*MAX_SIZE+c]) need_full = 1'b1;
                if (need_full) begin
                    for (int r = 0; r < n; r++) begin
                        for (int c = 0; c < n; c++) begin
                            // stray element outside the area in use
                            if (n < MAX_SIZE && $urandom_range(0, 7) == 0)
                                send_elem(rand_elem(), 3'($urandom_range(n, 7)),
                                          3'($urandom_range(0, 7)), 1'b0);
                            send_elem(rand_elem(), 3'(r), 3'(c),
                                      (r == n - 1) && (c == n - 1));
                        end
                    end
                end else begin
                    // partial reload on top of the reduced matrix
                    k = $urandom_range(0, n * n / 2);
                    repeat (k)
                        send_elem(rand_elem(), 3'($urandom_range(0, n - 1)),
                                  3'($urandom_range(0, n - 1)), 1'b0);
                    send_elem(rand_elem(), 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), 1'b1);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_inverse.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
